>>> hdl/bcf_pkg.sv
// shared types for the barometric compensation filter
`default_nettype none

package bcf_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_ADD,
    ST_T_DIV,
    ST_OFF_DIV,
    ST_OFF_ADD,
    ST_SENS_DIV,
    ST_SENS_ADD,
    ST_A_SUB,
    ST_A_SQ,
    ST_OFF2_MUL5,
    ST_OFF2_SUB,
    ST_SENS2_SUB,
    ST_T2_SUB,
    ST_B_ADD,
    ST_B_SQ,
    ST_OFF3_MUL7,
    ST_OFF3_SUB,
    ST_SENS3_X10,
    ST_SENS3_X11,
    ST_SENS3_SUB,
    ST_P_MLO,
    ST_P_MHI,
    ST_P_ACC,
    ST_P_DIV1,
    ST_P_SUB,
    ST_P_DIV2,
    ST_DONE
  } bcf_state_t;

  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] off_base;
    logic [15:0] sens_tempco;
    logic [15:0] off_tempco;
    logic [15:0] ref_temp;
    logic [15:0] temp_slope;
  } bcf_coef_t;

  typedef struct packed {
    logic signed [19:0] temperature;
    logic signed [31:0] pressure;
  } bcf_result_t;

  typedef struct packed {
    logic idle;
    logic done;
  } bcf_status_t;

endpackage

`default_nettype wire

>>> hdl/bcf_mul.sv
// shared registered signed multiplier
`default_nettype none

module bcf_mul (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [25:0] a,
  input  wire logic signed [25:0] b,
  output logic signed [51:0]      prod
);

  logic signed [51:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

>>> hdl/bcf_hold.sv
// debounce filter that holds the compensated pressure
`default_nettype none

module bcf_hold (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               upd,
  input  wire logic signed [31:0] pressure,
  input  wire logic [7:0]         confirm,
  output logic signed [31:0]      held_nxt
);

  logic               first_r;
  logic [7:0]         up_r;
  logic [7:0]         down_r;
  logic signed [31:0] held_r;

  logic signed [31:0] held_eff;
  logic               gt;
  logic               lt;
  logic [7:0]         up_inc;
  logic [7:0]         down_inc;
  logic               replace;
  logic               equal;

  always_comb begin
    held_eff = first_r ? pressure : held_r;
    gt       = pressure > held_eff;
    lt       = pressure < held_eff;
    up_inc   = (gt && (up_r != 8'hFF)) ? up_r + 8'd1 : up_r;
    down_inc = (lt && (down_r != 8'hFF)) ? down_r + 8'd1 : down_r;
    replace  = (up_inc >= confirm) || (down_inc >= confirm);
    held_nxt = replace ? pressure : held_eff;
    equal    = replace || (!gt && !lt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      up_r    <= 8'd0;
      down_r  <= 8'd0;
      held_r  <= 32'sd0;
    end else if (upd) begin
      first_r <= 1'b0;
      up_r    <= equal ? 8'd0 : up_inc;
      down_r  <= equal ? 8'd0 : down_inc;
      held_r  <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> (held_r == $past(held_r)) || ((up_r == 8'd0) && (down_r == 8'd0)))
    else $error("hold changed with counts left over");
`endif

endmodule

`default_nettype wire

>>> hdl/bcf_core.sv
// sequencer and datapath for temperature and pressure compensation
`default_nettype none

module bcf_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              take,
  input  wire logic [23:0]       d1,
  input  wire logic [23:0]       d2,
  input  wire bcf_pkg::bcf_coef_t coef,
  output bcf_pkg::bcf_status_t   status,
  output bcf_pkg::bcf_result_t   result
);

  localparam logic [63:0]        T_NUM_BIAS = 64'd16781410304;
  localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
  localparam logic signed [19:0] COLD_LIMIT = -20'sd1500;
  localparam logic [4:0]         SH_T1      = 5'd23;
  localparam logic [4:0]         SH_OFF     = 5'd7;
  localparam logic [4:0]         SH_SENS    = 5'd8;
  localparam logic [4:0]         SH_P1      = 5'd21;
  localparam logic [4:0]         SH_P2      = 5'd15;

  bcf_pkg::bcf_state_t state_r;
  bcf_pkg::bcf_state_t state_nxt;

  logic [23:0]        d1_r;
  logic [24:0]        dt_r;
  logic signed [19:0] t1_r;
  logic [19:0]        temp_r;
  logic [63:0]        off_r;
  logic [63:0]        sens_r;
  logic [63:0]        acc_r;

  logic               mul_en;
  logic signed [25:0] mul_a;
  logic signed [25:0] mul_b;
  logic signed [51:0] prod;
  logic [63:0]        prod64;

  logic [63:0] add_a;
  logic [63:0] add_b;
  logic        add_cin;
  logic        use_bias;
  logic [4:0]  sh_amt;
  logic [63:0] bias;
  logic [63:0] sum;
  logic [63:0] sum_sh;
  logic [63:0] t1x;
  logic [63:0] ref_x;
  logic [63:0] cold_x;
  logic signed [25:0] dt_s;

  bcf_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod64 = {{12{prod[51]}}, prod};
  assign t1x    = {{44{t1_r[19]}}, t1_r};
  assign ref_x  = {{44{TEMP_REF[19]}}, TEMP_REF};
  assign cold_x = {{44{COLD_LIMIT[19]}}, COLD_LIMIT};
  assign dt_s   = {dt_r[24], dt_r};
  assign bias   = add_a[63] ? ((64'd1 << sh_amt) - 64'd1) : 64'd0;
  assign sum    = add_a + (use_bias ? bias : add_b) + {63'd0, add_cin};
  assign sum_sh = $unsigned($signed(sum) >>> sh_amt);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bcf_pkg::ST_IDLE:      if (start) state_nxt = bcf_pkg::ST_T_MUL;
      bcf_pkg::ST_T_MUL:     state_nxt = bcf_pkg::ST_T_ADD;
      bcf_pkg::ST_T_ADD:     state_nxt = bcf_pkg::ST_T_DIV;
      bcf_pkg::ST_T_DIV:     state_nxt = bcf_pkg::ST_OFF_DIV;
      bcf_pkg::ST_OFF_DIV:   state_nxt = bcf_pkg::ST_OFF_ADD;
      bcf_pkg::ST_OFF_ADD:   state_nxt = bcf_pkg::ST_SENS_DIV;
      bcf_pkg::ST_SENS_DIV:  state_nxt = bcf_pkg::ST_SENS_ADD;
      bcf_pkg::ST_SENS_ADD: begin
        state_nxt = (t1_r < TEMP_REF) ? bcf_pkg::ST_A_SUB : bcf_pkg::ST_P_MLO;
      end
      bcf_pkg::ST_A_SUB:     state_nxt = bcf_pkg::ST_A_SQ;
      bcf_pkg::ST_A_SQ:      state_nxt = bcf_pkg::ST_OFF2_MUL5;
      bcf_pkg::ST_OFF2_MUL5: state_nxt = bcf_pkg::ST_OFF2_SUB;
      bcf_pkg::ST_OFF2_SUB:  state_nxt = bcf_pkg::ST_SENS2_SUB;
      bcf_pkg::ST_SENS2_SUB: state_nxt = bcf_pkg::ST_T2_SUB;
      bcf_pkg::ST_T2_SUB: begin
        state_nxt = (t1_r < COLD_LIMIT) ? bcf_pkg::ST_B_ADD : bcf_pkg::ST_P_MLO;
      end
      bcf_pkg::ST_B_ADD:     state_nxt = bcf_pkg::ST_B_SQ;
      bcf_pkg::ST_B_SQ:      state_nxt = bcf_pkg::ST_OFF3_MUL7;
      bcf_pkg::ST_OFF3_MUL7: state_nxt = bcf_pkg::ST_OFF3_SUB;
      bcf_pkg::ST_OFF3_SUB:  state_nxt = bcf_pkg::ST_SENS3_X10;
      bcf_pkg::ST_SENS3_X10: state_nxt = bcf_pkg::ST_SENS3_X11;
      bcf_pkg::ST_SENS3_X11: state_nxt = bcf_pkg::ST_SENS3_SUB;
      bcf_pkg::ST_SENS3_SUB: state_nxt = bcf_pkg::ST_P_MLO;
      bcf_pkg::ST_P_MLO:     state_nxt = bcf_pkg::ST_P_MHI;
      bcf_pkg::ST_P_MHI:     state_nxt = bcf_pkg::ST_P_ACC;
      bcf_pkg::ST_P_ACC:     state_nxt = bcf_pkg::ST_P_DIV1;
      bcf_pkg::ST_P_DIV1:    state_nxt = bcf_pkg::ST_P_SUB;
      bcf_pkg::ST_P_SUB:     state_nxt = bcf_pkg::ST_P_DIV2;
      bcf_pkg::ST_P_DIV2:    state_nxt = bcf_pkg::ST_DONE;
      bcf_pkg::ST_DONE:      if (take) state_nxt = bcf_pkg::ST_IDLE;
      default:               state_nxt = bcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    add_a    = 64'd0;
    add_b    = 64'd0;
    add_cin  = 1'b0;
    use_bias = 1'b0;
    sh_amt   = 5'd0;
    mul_en   = 1'b0;
    mul_a    = 26'sd0;
    mul_b    = 26'sd0;
    case (state_r)
      bcf_pkg::ST_IDLE: begin
        add_a   = {40'd0, d2};
        add_b   = ~{40'd0, coef.ref_temp, 8'd0};
        add_cin = 1'b1;
      end
      bcf_pkg::ST_T_MUL: begin
        mul_en = 1'b1;
        mul_a  = dt_s;
        mul_b  = $signed({10'd0, coef.temp_slope});
      end
      bcf_pkg::ST_T_ADD: begin
        add_a = prod64;
        add_b = T_NUM_BIAS;
      end
      bcf_pkg::ST_T_DIV: begin
        add_a    = acc_r;
        use_bias = 1'b1;
        sh_amt   = SH_T1;
        mul_en   = 1'b1;
        mul_a    = dt_s;
        mul_b    = $signed({10'd0, coef.off_tempco});
      end
      bcf_pkg::ST_OFF_DIV: begin
        add_a    = prod64;
        use_bias = 1'b1;
        sh_amt   = SH_OFF;
        mul_en   = 1'b1;
        mul_a    = dt_s;
        mul_b    = $signed({10'd0, coef.sens_tempco});
      end
      bcf_pkg::ST_OFF_ADD: begin
        add_a = off_r;
        add_b = {32'd0, coef.off_base, 16'd0};
      end
      bcf_pkg::ST_SENS_DIV: begin
        add_a    = prod64;
        use_bias = 1'b1;
        sh_amt   = SH_SENS;
      end
      bcf_pkg::ST_SENS_ADD: begin
        add_a = sens_r;
        add_b = {33'd0, coef.sens_base, 15'd0};
      end
      bcf_pkg::ST_A_SUB: begin
        add_a   = t1x;
        add_b   = ~ref_x;
        add_cin = 1'b1;
      end
      bcf_pkg::ST_A_SQ, bcf_pkg::ST_B_SQ: begin
        mul_en = 1'b1;
        mul_a  = $signed(acc_r[25:0]);
        mul_b  = $signed(acc_r[25:0]);
      end
      bcf_pkg::ST_OFF2_MUL5: begin
        add_a = prod64 << 2;
        add_b = prod64;
      end
      bcf_pkg::ST_OFF2_SUB: begin
        add_a   = off_r;
        add_b   = ~(acc_r >> 1);
        add_cin = 1'b1;
      end
      bcf_pkg::ST_SENS2_SUB: begin
        add_a   = sens_r;
        add_b   = ~(acc_r >> 2);
        add_cin = 1'b1;
        mul_en  = 1'b1;
        mul_a   = dt_s;
        mul_b   = dt_s;
      end
      bcf_pkg::ST_T2_SUB: begin
        add_a   = t1x;
        add_b   = ~(prod64 >> 31);
        add_cin = 1'b1;
      end
      bcf_pkg::ST_B_ADD: begin
        add_a   = t1x;
        add_b   = ~cold_x;
        add_cin = 1'b1;
      end
      bcf_pkg::ST_OFF3_MUL7: begin
        add_a   = prod64 << 3;
        add_b   = ~prod64;
        add_cin = 1'b1;
      end
      bcf_pkg::ST_OFF3_SUB: begin
        add_a   = off_r;
        add_b   = ~acc_r;
        add_cin = 1'b1;
      end
      bcf_pkg::ST_SENS3_X10: begin
        add_a = prod64 << 3;
        add_b = prod64 << 1;
      end
      bcf_pkg::ST_SENS3_X11: begin
        add_a = acc_r;
        add_b = prod64;
      end
      bcf_pkg::ST_SENS3_SUB: begin
        add_a   = sens_r;
        add_b   = ~(acc_r >> 1);
        add_cin = 1'b1;
      end
      bcf_pkg::ST_P_MLO: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'd0, d1_r});
        mul_b  = $signed({6'd0, sens_r[19:0]});
      end
      bcf_pkg::ST_P_MHI: begin
        add_a  = prod64;
        mul_en = 1'b1;
        mul_a  = $signed({2'd0, d1_r});
        mul_b  = $signed(sens_r[45:20]);
      end
      bcf_pkg::ST_P_ACC: begin
        add_a = acc_r;
        add_b = prod64 << 20;
      end
      bcf_pkg::ST_P_DIV1: begin
        add_a    = acc_r;
        use_bias = 1'b1;
        sh_amt   = SH_P1;
      end
      bcf_pkg::ST_P_SUB: begin
        add_a   = acc_r;
        add_b   = ~off_r;
        add_cin = 1'b1;
      end
      bcf_pkg::ST_P_DIV2: begin
        add_a    = acc_r;
        use_bias = 1'b1;
        sh_amt   = SH_P2;
      end
      default: begin
        add_a = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bcf_pkg::ST_IDLE: begin
        if (start) begin
          d1_r <= d1;
          dt_r <= sum[24:0];
        end
      end
      bcf_pkg::ST_T_DIV: begin
        t1_r   <= $signed(sum_sh[19:0]);
        temp_r <= sum_sh[19:0];
      end
      bcf_pkg::ST_OFF_DIV, bcf_pkg::ST_OFF_ADD, bcf_pkg::ST_OFF2_SUB,
      bcf_pkg::ST_OFF3_SUB: begin
        off_r <= sum_sh;
      end
      bcf_pkg::ST_SENS_DIV, bcf_pkg::ST_SENS_ADD, bcf_pkg::ST_SENS2_SUB,
      bcf_pkg::ST_SENS3_SUB: begin
        sens_r <= sum_sh;
      end
      bcf_pkg::ST_T2_SUB: begin
        temp_r <= sum_sh[19:0];
      end
      bcf_pkg::ST_T_ADD, bcf_pkg::ST_A_SUB, bcf_pkg::ST_OFF2_MUL5, bcf_pkg::ST_B_ADD,
      bcf_pkg::ST_OFF3_MUL7, bcf_pkg::ST_SENS3_X10, bcf_pkg::ST_SENS3_X11,
      bcf_pkg::ST_P_MHI, bcf_pkg::ST_P_ACC, bcf_pkg::ST_P_DIV1, bcf_pkg::ST_P_SUB,
      bcf_pkg::ST_P_DIV2: begin
        acc_r <= sum_sh;
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  assign status.idle          = (state_r == bcf_pkg::ST_IDLE);
  assign status.done          = (state_r == bcf_pkg::ST_DONE);
  assign result.temperature   = $signed(temp_r);
  assign result.pressure      = $signed(acc_r[31:0]);

`ifndef SYNTHESIS
  a_dt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bcf_pkg::ST_IDLE) |=> $stable(dt_r))
    else $error("temperature difference changed mid computation");

  a_cold_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bcf_pkg::ST_T2_SUB) |-> (t1_r < TEMP_REF))
    else $error("second order path entered when warm");
`endif

endmodule

`default_nettype wire

>>> hdl/baro_sensor_compensation_filter.sv
// top level of the barometric compensation filter
//
// in channel: one transfer carries a raw pressure and a raw temperature
// conversion. out channel: one transfer per input carries the compensated
// temperature, compensated pressure and the debounced held pressure.
// cfg port: cfg_we writes cfg_wdata into the register at cfg_index
// (0..5 calibration words, 6 confirm count); other indexes are ignored.
// an item runs through one shared adder and one registered 26x26
// multiplier under a sequencer, with more steps below 20.00 degrees and
// more again below -15.00 degrees; in_tready rises in the same cycle as
// out_tvalid, and no new item is taken before the last one is finished.
// in_tready is high only while the sequencer is idle. the output register
// lets the next item start while a result waits; a finished item waits
// in the sequencer while the receiver stalls. synchronous reset clears
// the calibration words, sets the confirm count to 10 and restarts the
// filter with no sample seen.
`default_nettype none

module baro_sensor_compensation_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // pressure_raw, temperature_raw
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata, // temperature_out, pressure_out, pressure_held
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  localparam logic [2:0] REG_SENS_BASE   = 3'd0;
  localparam logic [2:0] REG_OFF_BASE    = 3'd1;
  localparam logic [2:0] REG_SENS_TEMPCO = 3'd2;
  localparam logic [2:0] REG_OFF_TEMPCO  = 3'd3;
  localparam logic [2:0] REG_REF_TEMP    = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE  = 3'd5;
  localparam logic [2:0] REG_CONFIRM     = 3'd6;

  bcf_pkg::bcf_coef_t   coef_r;
  logic [7:0]           confirm_r;
  bcf_pkg::bcf_status_t status;
  bcf_pkg::bcf_result_t result;
  logic                 start;
  logic                 take;
  logic signed [31:0]   held_nxt;
  logic                 out_tvalid_r;
  logic [87:0]          out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r    <= '0;
      confirm_r <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS_BASE:   coef_r.sens_base   <= cfg_wdata;
        REG_OFF_BASE:    coef_r.off_base    <= cfg_wdata;
        REG_SENS_TEMPCO: coef_r.sens_tempco <= cfg_wdata;
        REG_OFF_TEMPCO:  coef_r.off_tempco  <= cfg_wdata;
        REG_REF_TEMP:    coef_r.ref_temp    <= cfg_wdata;
        REG_TEMP_SLOPE:  coef_r.temp_slope  <= cfg_wdata;
        REG_CONFIRM:     confirm_r          <= cfg_wdata[7:0];
        default:         confirm_r          <= confirm_r;
      endcase
    end
  end

  assign in_tready = status.idle;
  assign start     = in_tvalid && status.idle;
  assign take      = status.done && (!out_tvalid_r || out_tready);

  bcf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .take   (take),
    .d1     (in_tdata[23:0]),
    .d2     (in_tdata[47:24]),
    .coef   (coef_r),
    .status (status),
    .result (result)
  );

  bcf_hold u_hold (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (take),
    .pressure (result.pressure),
    .confirm  (confirm_r),
    .held_nxt (held_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {4'd0, held_nxt, result.pressure, result.temperature};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(status.done))
    else $error("output became valid without a finished item");
`endif

endmodule

`default_nettype wire
